/* hdl/multi_channel_task_watchdog_top_assert.svh */
// Assertion macros for the task watchdog
`ifndef MULTI_CHANNEL_TASK_WATCHDOG_TOP_ASSERT_SVH
`define MULTI_CHANNEL_TASK_WATCHDOG_TOP_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define MCTW_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define MCTW_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

/* hdl/mctw_pkg.sv */
// ----------------------------------------------------------------------------
// mctw_pkg
// Types, codes and sizes shared by the task watchdog modules.
// ----------------------------------------------------------------------------
package mctw_pkg;
	localparam int SlotCount = 8;
	localparam int SlotW = (SlotCount > 1) ? $clog2(SlotCount) : 1;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_REMOVE = 3'd1;
	localparam logic [2:0] OP_FEED = 3'd2;
	localparam logic [2:0] OP_SETACT = 3'd3;
	localparam logic [2:0] OP_QUERY = 3'd4;
	localparam logic [2:0] OP_TICK = 3'd5;
	localparam logic [2:0] OP_CHECK = 3'd6;
	localparam logic [2:0] OP_UNUSED = 3'd7;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BADARG = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_HALTED = 2'd3;

	localparam logic [1:0] ACT_REPORT = 2'd0;
	localparam logic [1:0] ACT_RESET = 2'd1;
	localparam logic [1:0] ACT_SUSPEND = 2'd2;
	localparam logic [1:0] ACT_DELETE = 2'd3;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [7:0]  task_id;
		logic [31:0] expiry_ticks;
		logic [1:0]  action_code;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        is_enabled;
		logic [31:0] ticks_remaining;
		logic        expired;
		logic [7:0]  expired_task;
		logic [1:0]  expired_action;
		logic        last;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_APPLY, S_WALK, S_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic latch;     // capture command, clear index
		logic step;      // advance slot index
		logic apply;     // perform the command's update
		logic walk_hit;  // apply action on current slot and emit beat
		logic emit;      // emit a closing beat
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic halted;
		logic idx_last;
		logic early;     // command resolved without a scan
		logic slot_exp;  // current slot expired in a check
		logic exp_reset; // its action is reset
	} sts_t;
endpackage

/* hdl/multi_channel_task_watchdog_top.sv */
// ----------------------------------------------------------------------------
// multi_channel_task_watchdog_top
// Per-task watchdog table with command interface and strobed results.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Each result beat
// shows for one cycle with result_valid high and cannot be held off. A
// command keeps busy high while a single sequencer visits one slot per
// cycle; a check walks every slot unless a reset action ends its walk
// early; tick, rejected and halted commands skip the scan. A check emits
// one beat per expired slot as the walk reaches it, then a closing beat with
// last set.
module multi_channel_task_watchdog_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  mctw_pkg::cmd_t  cmd,
	output logic            busy,
	output logic            result_valid,
	output mctw_pkg::rsp_t  result
);
	mctw_pkg::ctl_t ctl;
	mctw_pkg::sts_t sts;
	logic [2:0] op;

	mctw_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .op(op),
		.sts(sts), .ctl(ctl), .busy(busy)
	);

	mctw_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .ctl(ctl), .sts(sts),
		.op(op), .result(result), .result_valid(result_valid)
	);
endmodule

/* hdl/mctw_ctrl.sv */
// ----------------------------------------------------------------------------
// mctw_ctrl
// Sequencer: scans slots one per cycle, then applies or reports.
// ----------------------------------------------------------------------------
`include "multi_channel_task_watchdog_top_assert.svh"
module mctw_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [2:0]      op,
	input  mctw_pkg::sts_t  sts,
	output mctw_pkg::ctl_t  ctl,
	output logic            busy
);
	mctw_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mctw_pkg::S_IDLE;
		else state_q <= state_d;
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		ctl = '0;
		busy = (state_q != mctw_pkg::S_IDLE);
		unique case (state_q)
			mctw_pkg::S_IDLE: begin
				if (start) begin
					ctl.latch = 1'b1;
					state_d = mctw_pkg::S_SCAN;
				end
			end
			mctw_pkg::S_SCAN: begin
				if (sts.early) state_d = mctw_pkg::S_DONE;
				else if (op == mctw_pkg::OP_CHECK) state_d = mctw_pkg::S_WALK;
				else if (sts.idx_last) state_d = mctw_pkg::S_APPLY;
				else ctl.step = 1'b1;
			end
			mctw_pkg::S_APPLY: begin
				ctl.apply = 1'b1;
				ctl.emit = 1'b1;
				state_d = mctw_pkg::S_IDLE;
			end
			mctw_pkg::S_WALK: begin
				if (sts.slot_exp) ctl.walk_hit = 1'b1;
				if (sts.slot_exp && sts.exp_reset) state_d = mctw_pkg::S_DONE;
				else if (sts.idx_last) state_d = mctw_pkg::S_DONE;
				else ctl.step = 1'b1;
			end
			mctw_pkg::S_DONE: begin
				ctl.emit = 1'b1;
				state_d = mctw_pkg::S_IDLE;
			end
			default: state_d = mctw_pkg::S_IDLE;
		endcase
	end

	`MCTW_ASSERT_IMP(a_latch_idle, clk, arst_n, ctl.latch, state_q == mctw_pkg::S_IDLE)
	`MCTW_ASSERT_NXT(a_emit_idle, clk, arst_n, ctl.emit, !busy)
	`MCTW_ASSERT_IMP(a_one_cmd, clk, arst_n, 1'b1, $onehot0({ctl.latch, ctl.emit, ctl.walk_hit}))
endmodule

/* hdl/mctw_dp.sv */
// ----------------------------------------------------------------------------
// mctw_dp
// Slot table, tick counter, halted flag and result register.
// ----------------------------------------------------------------------------
`include "multi_channel_task_watchdog_top_assert.svh"
module mctw_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  mctw_pkg::cmd_t  cmd,
	input  mctw_pkg::ctl_t  ctl,
	output mctw_pkg::sts_t  sts,
	output logic [2:0]      op,
	output mctw_pkg::rsp_t  result,
	output logic            result_valid
);
	localparam int SW = mctw_pkg::SlotW;
	localparam int LastIdx = mctw_pkg::SlotCount - 1;

	logic [7:0]  task_q [mctw_pkg::SlotCount];
	logic [mctw_pkg::SlotCount-1:0] en_q;
	logic [31:0] tmo_q [mctw_pkg::SlotCount];
	logic [31:0] feed_q [mctw_pkg::SlotCount];
	logic [1:0]  act_q [mctw_pkg::SlotCount];
	logic [31:0] tick_q;
	logic        halted_q;
	mctw_pkg::cmd_t cmd_q;
	logic [SW-1:0] idx_q;
	logic        hit_q, free_q;
	logic [SW-1:0] hidx_q, fidx_q;
	logic        hit_now, free_now;
	logic [31:0] elapsed;
	logic        exp_now;
	logic        bad;

	assign op = cmd_q.opcode;

	// current-slot compare
	always_comb begin
		hit_now = (task_q[idx_q] != 8'd0) && (task_q[idx_q] == cmd_q.task_id);
		free_now = (task_q[idx_q] == 8'd0);
		elapsed = tick_q - feed_q[idx_q];
		exp_now = (task_q[idx_q] != 8'd0) && en_q[idx_q] && (elapsed >= tmo_q[idx_q]);
		bad = (cmd_q.opcode == mctw_pkg::OP_UNUSED)
			|| ((cmd_q.opcode <= mctw_pkg::OP_QUERY) && (cmd_q.task_id == 8'd0))
			|| ((cmd_q.opcode == mctw_pkg::OP_ADD) && (cmd_q.expiry_ticks == 32'd0));
		sts.halted = halted_q;
		sts.idx_last = (idx_q == SW'(LastIdx));
		sts.early = halted_q || bad || (cmd_q.opcode == mctw_pkg::OP_TICK);
		sts.slot_exp = exp_now;
		sts.exp_reset = (act_q[idx_q] == mctw_pkg::ACT_RESET);
	end

	// command capture and scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			hidx_q <= '0;
			fidx_q <= '0;
		end else if (ctl.latch) begin
			idx_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
		end else begin
			if (ctl.step || (cmd_q.opcode != mctw_pkg::OP_CHECK && !ctl.apply)) begin
				if (hit_now && !hit_q) begin
					hit_q <= 1'b1;
					hidx_q <= idx_q;
				end
				if (free_now && !free_q) begin
					free_q <= 1'b1;
					fidx_q <= idx_q;
				end
			end
			if (ctl.step) idx_q <= idx_q + SW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) cmd_q <= cmd;
	end

	// final hit and free, including the last slot seen this cycle
	logic fh, ff;
	logic [SW-1:0] fhi, ffi;
	always_comb begin
		fh = hit_q || hit_now;
		fhi = hit_q ? hidx_q : idx_q;
		ff = free_q || free_now;
		ffi = free_q ? fidx_q : idx_q;
	end

	// slot table, counter and halt
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mctw_pkg::SlotCount; i++) begin
				task_q[i] <= 8'd0;
				tmo_q[i] <= 32'd0;
				feed_q[i] <= 32'd0;
				act_q[i] <= 2'd0;
			end
			en_q <= '0;
			tick_q <= 32'd0;
			halted_q <= 1'b0;
		end else begin
			if (ctl.emit && !halted_q && !bad && cmd_q.opcode == mctw_pkg::OP_TICK)
				tick_q <= tick_q + 32'd1;
			if (ctl.apply) begin
				unique case (cmd_q.opcode)
					mctw_pkg::OP_ADD: begin
						if (fh) begin
							tmo_q[fhi] <= cmd_q.expiry_ticks;
							feed_q[fhi] <= tick_q;
							en_q[fhi] <= 1'b1;
						end else if (ff) begin
							task_q[ffi] <= cmd_q.task_id;
							act_q[ffi] <= mctw_pkg::ACT_REPORT;
							tmo_q[ffi] <= cmd_q.expiry_ticks;
							feed_q[ffi] <= tick_q;
							en_q[ffi] <= 1'b1;
						end
					end
					mctw_pkg::OP_REMOVE: if (fh) begin
						task_q[fhi] <= 8'd0;
						en_q[fhi] <= 1'b0;
					end
					mctw_pkg::OP_FEED: if (fh && en_q[fhi]) feed_q[fhi] <= tick_q;
					mctw_pkg::OP_SETACT: if (fh) act_q[fhi] <= cmd_q.action_code;
					default: ;
				endcase
			end
			if (ctl.walk_hit) begin
				unique case (act_q[idx_q])
					mctw_pkg::ACT_RESET: halted_q <= 1'b1;
					mctw_pkg::ACT_SUSPEND: en_q[idx_q] <= 1'b0;
					mctw_pkg::ACT_DELETE: begin
						task_q[idx_q] <= 8'd0;
						en_q[idx_q] <= 1'b0;
					end
					default: feed_q[idx_q] <= tick_q;
				endcase
			end
		end
	end

	// result register
	logic [31:0] q_el;
	mctw_pkg::rsp_t rsp_d;
	always_comb q_el = tick_q - feed_q[fhi];

	always_comb begin
		rsp_d = '0;
		if (ctl.walk_hit) begin
			rsp_d.expired = 1'b1;
			rsp_d.expired_task = task_q[idx_q];
			rsp_d.expired_action = act_q[idx_q];
		end else begin
			rsp_d.last = 1'b1;
			if (halted_q) rsp_d.status = mctw_pkg::ST_HALTED;
			else if (bad) rsp_d.status = mctw_pkg::ST_BADARG;
			else if (cmd_q.opcode == mctw_pkg::OP_ADD && !fh && !ff)
				rsp_d.status = mctw_pkg::ST_FULL;
			else if (cmd_q.opcode == mctw_pkg::OP_QUERY && fh && en_q[fhi]) begin
				rsp_d.is_enabled = 1'b1;
				if (q_el < tmo_q[fhi]) rsp_d.ticks_remaining = tmo_q[fhi] - q_el;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else result_valid <= ctl.emit || ctl.walk_hit;
	end

	always_ff @(posedge clk) begin
		result <= rsp_d;
	end

	`MCTW_ASSERT_NXT(a_halt_sticky, clk, arst_n, halted_q, halted_q)
	`MCTW_ASSERT_IMP(a_walk_check, clk, arst_n, ctl.walk_hit, cmd_q.opcode == mctw_pkg::OP_CHECK)
	`MCTW_ASSERT_NXT(a_hit_beat, clk, arst_n, ctl.walk_hit, result_valid && result.expired)
endmodule

/* tb/sv/mctw_checker.sv */
// ----------------------------------------------------------------------------
// mctw_checker
// Watches the command and result channels of the task watchdog, keeps its own
// copy of the slot table and compares every result beat with the prediction.
// ----------------------------------------------------------------------------
module mctw_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  mctw_pkg::cmd_t  cmd,
	input  logic            busy,
	input  logic            result_valid,
	input  mctw_pkg::rsp_t  result,
	output int              fail_count,
	output int              pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// shadow slot table
	logic [7:0]  wd_task [mctw_pkg::SlotCount];
	logic        wd_en [mctw_pkg::SlotCount];
	logic [31:0] wd_tmo [mctw_pkg::SlotCount];
	logic [31:0] wd_fed [mctw_pkg::SlotCount];
	logic [1:0]  wd_act [mctw_pkg::SlotCount];
	logic [31:0] wd_now;
	logic        wd_halted;

	mctw_pkg::rsp_t expected_beats[$];

	function automatic mctw_pkg::rsp_t mk_rsp(logic [1:0] st, logic lst);
		mctw_pkg::rsp_t r;
		r = '0;
		r.status = st;
		r.last = lst;
		return r;
	endfunction

	function automatic int find_task(logic [7:0] id);
		for (int i = 0; i < mctw_pkg::SlotCount; i++)
			if (wd_task[i] != 8'd0 && wd_task[i] == id) return i;
		return -1;
	endfunction

	// advance the shadow table by one command and queue its beats
	task automatic predict_watchdog(mctw_pkg::cmd_t c);
		int s;
		mctw_pkg::rsp_t r;
		logic [31:0] el;
		if (wd_halted) begin
			expected_beats.push_back(mk_rsp(mctw_pkg::ST_HALTED, 1'b1));
			return;
		end
		if (c.opcode <= mctw_pkg::OP_QUERY && c.task_id == 8'd0) begin
			expected_beats.push_back(mk_rsp(mctw_pkg::ST_BADARG, 1'b1));
			return;
		end
		s = find_task(c.task_id);
		r = mk_rsp(mctw_pkg::ST_OK, 1'b1);
		case (c.opcode)
			mctw_pkg::OP_ADD: begin
				if (c.expiry_ticks == 32'd0) r.status = mctw_pkg::ST_BADARG;
				else begin
					if (s < 0) begin
						for (int i = mctw_pkg::SlotCount - 1; i >= 0; i--)
							if (wd_task[i] == 8'd0) s = i;
						if (s >= 0) begin
							wd_task[s] = c.task_id;
							wd_act[s] = mctw_pkg::ACT_REPORT;
						end
					end
					if (s < 0) r.status = mctw_pkg::ST_FULL;
					else begin
						wd_tmo[s] = c.expiry_ticks;
						wd_fed[s] = wd_now;
						wd_en[s] = 1'b1;
					end
				end
			end
			mctw_pkg::OP_REMOVE: if (s >= 0) begin
				wd_task[s] = 8'd0;
				wd_en[s] = 1'b0;
			end
			mctw_pkg::OP_FEED: if (s >= 0 && wd_en[s]) wd_fed[s] = wd_now;
			mctw_pkg::OP_SETACT: if (s >= 0) wd_act[s] = c.action_code;
			mctw_pkg::OP_QUERY: if (s >= 0 && wd_en[s]) begin
				el = wd_now - wd_fed[s];
				r.is_enabled = 1'b1;
				if (el < wd_tmo[s]) r.ticks_remaining = wd_tmo[s] - el;
			end
			mctw_pkg::OP_TICK: wd_now = wd_now + 32'd1;
			mctw_pkg::OP_CHECK: begin
				for (int i = 0; i < mctw_pkg::SlotCount; i++) begin
					mctw_pkg::rsp_t e;
					if (wd_task[i] == 8'd0 || !wd_en[i]) continue;
					if (wd_now - wd_fed[i] < wd_tmo[i]) continue;
					e = mk_rsp(mctw_pkg::ST_OK, 1'b0);
					e.expired = 1'b1;
					e.expired_task = wd_task[i];
					e.expired_action = wd_act[i];
					expected_beats.push_back(e);
					if (wd_act[i] == mctw_pkg::ACT_RESET) begin
						wd_halted = 1'b1;
						break;
					end
					else if (wd_act[i] == mctw_pkg::ACT_SUSPEND) wd_en[i] = 1'b0;
					else if (wd_act[i] == mctw_pkg::ACT_DELETE) begin
						wd_task[i] = 8'd0;
						wd_en[i] = 1'b0;
					end
					else wd_fed[i] = wd_now;
				end
				if (wd_halted) r.status = mctw_pkg::ST_HALTED;
			end
			default: r.status = mctw_pkg::ST_BADARG;
		endcase
		expected_beats.push_back(r);
	endtask

	assign pending = expected_beats.size();

	always @(posedge clk or negedge arst_n) begin
		mctw_pkg::rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < mctw_pkg::SlotCount; i++) begin
				wd_task[i] = '0;
				wd_en[i] = 1'b0;
				wd_tmo[i] = '0;
				wd_fed[i] = '0;
				wd_act[i] = mctw_pkg::ACT_REPORT;
			end
			wd_now = '0;
			wd_halted = 1'b0;
			expected_beats.delete();
			fail_count = 0;
		end
		else begin
			// results are compared before the command of the same edge is predicted
			if (result_valid) begin
				if (expected_beats.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected result beat %p", $realtime, result);
				end
				else begin
					want = expected_beats.pop_front();
					if (result !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: mismatch expected %p actual %p",
								$realtime, want, result);
					end
				end
			end
			if (start && !busy) predict_watchdog(cmd);
		end
	end
endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random watchdog commands into the block with random
// gaps; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RandCount = 240;
	localparam int StallLimit = 2000;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	mctw_pkg::cmd_t  cmd = '0;
	logic  busy;
	logic  result_valid;
	mctw_pkg::rsp_t  result;
	int    fail_count;
	int    pending;
	int    idle_cycles = 0;
	logic [7:0] id_pool [4];

	multi_channel_task_watchdog_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd),
		.busy(busy), .result_valid(result_valid), .result(result)
	);

	mctw_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .busy(busy),
		.result_valid(result_valid), .result(result),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// stall watchdog: cycles with no beat moving either way
	always @(posedge clk) begin
		if ((start && !busy) || result_valid) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > StallLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// present one command and hold it until accepted
	task automatic send_cmd(logic [2:0] op, logic [7:0] id, logic [31:0] tmo,
			logic [1:0] act);
		start <= 1'b1;
		cmd <= '{opcode: op, task_id: id, expiry_ticks: tmo, action_code: act};
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic random_gap(bit allow);
		int n;
		if (allow && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 16);
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic random_cmd(bit allow);
		logic [2:0]  op;
		logic [7:0]  id;
		logic [31:0] tmo;
		logic [1:0]  act;
		int k;
		k = $urandom_range(0, 99);
		id = (k < 90) ? id_pool[$urandom_range(0, 3)] : 8'($urandom);
		op = 3'($urandom_range(0, 7));
		if (k < 60) op = (k < 20) ? mctw_pkg::OP_TICK : (k < 35) ? mctw_pkg::OP_CHECK
			: mctw_pkg::OP_ADD;
		tmo = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 6));
		// reset actions are left to the closing sequence
		act = 2'($urandom);
		if (act == mctw_pkg::ACT_RESET) act = mctw_pkg::ACT_REPORT;
		random_gap(allow);
		send_cmd(op, id, tmo, act);
	endtask

	initial begin
		for (int i = 0; i < 4; i++) id_pool[i] = 8'($urandom_range(1, 255));
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: bad arguments, full table, report and suspend actions, largest expiry
		send_cmd(mctw_pkg::OP_ADD, 8'd0, 32'd5, mctw_pkg::ACT_REPORT);
		send_cmd(mctw_pkg::OP_ADD, 8'd1, 32'd0, mctw_pkg::ACT_REPORT);
		send_cmd(mctw_pkg::OP_UNUSED, 8'd1, 32'd1, mctw_pkg::ACT_REPORT);
		for (int i = 1; i <= mctw_pkg::SlotCount; i++)
			send_cmd(mctw_pkg::OP_ADD, 8'(i == mctw_pkg::SlotCount ? 255 : i), 32'(i),
				mctw_pkg::ACT_REPORT);
		send_cmd(mctw_pkg::OP_ADD, 8'd77, 32'hFFFF_FFFF, mctw_pkg::ACT_REPORT);
		send_cmd(mctw_pkg::OP_SETACT, 8'd2, 32'd0, mctw_pkg::ACT_SUSPEND);
		send_cmd(mctw_pkg::OP_SETACT, 8'd3, 32'd0, mctw_pkg::ACT_DELETE);
		send_cmd(mctw_pkg::OP_FEED, 8'd9, 32'd0, mctw_pkg::ACT_REPORT);
		send_cmd(mctw_pkg::OP_REMOVE, 8'd5, 32'd0, mctw_pkg::ACT_REPORT);
		send_cmd(mctw_pkg::OP_TICK, 8'd0, 32'd0, mctw_pkg::ACT_REPORT);
		send_cmd(mctw_pkg::OP_TICK, 8'd0, 32'd0, mctw_pkg::ACT_REPORT);
		send_cmd(mctw_pkg::OP_QUERY, 8'd4, 32'd0, mctw_pkg::ACT_REPORT);
		send_cmd(mctw_pkg::OP_QUERY, 8'd255, 32'd0, mctw_pkg::ACT_REPORT);
		send_cmd(mctw_pkg::OP_CHECK, 8'd0, 32'd0, mctw_pkg::ACT_REPORT);
		send_cmd(mctw_pkg::OP_FEED, 8'd2, 32'd0, mctw_pkg::ACT_REPORT);
		send_cmd(mctw_pkg::OP_ADD, 8'd3, 32'hFFFF_FFFF, mctw_pkg::ACT_REPORT);
		send_cmd(mctw_pkg::OP_QUERY, 8'd3, 32'd0, mctw_pkg::ACT_REPORT);

		// hold off until the table has answered everything
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);

		// random traffic; halting ends useful work so the table is never reset
		for (int n = 0; n < RandCount; n++) random_cmd(n < RandCount - 30);
		send_cmd(mctw_pkg::OP_SETACT, id_pool[0], 32'd0, mctw_pkg::ACT_RESET);
		send_cmd(mctw_pkg::OP_ADD, id_pool[0], 32'd1, mctw_pkg::ACT_REPORT);
		send_cmd(mctw_pkg::OP_TICK, 8'd0, 32'd0, mctw_pkg::ACT_REPORT);
		send_cmd(mctw_pkg::OP_CHECK, 8'd0, 32'd0, mctw_pkg::ACT_REPORT);
		send_cmd(mctw_pkg::OP_QUERY, 8'd1, 32'd0, mctw_pkg::ACT_REPORT);
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule
